// File: rtl/core/jsp_pkg.sv
// ----------------------------------------------------------------------------
// jsp_pkg
// Shared types, codes and helper functions of the JSON object stream parser.
// ----------------------------------------------------------------------------
`default_nettype none

package jsp_pkg;

  localparam int MAX_NEST = 255;
  localparam int NEST_W   = ($clog2(MAX_NEST + 1) > 3) ? $clog2(MAX_NEST + 1) : 3;
  localparam logic [NEST_W-1:0] MAX_NEST_V = NEST_W'(MAX_NEST);

  localparam int IN_TDATA_W = 8;
  localparam int RES_W      = 17;
  localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

  typedef enum logic [3:0] {
    PH_BRACE     = 4'd0,
    PH_TOP       = 4'd1,
    PH_KEYWS     = 4'd2,
    PH_KEY       = 4'd3,
    PH_KEYESC    = 4'd4,
    PH_KEYBAD    = 4'd5,
    PH_KEYBADESC = 4'd6,
    PH_COLON     = 4'd7,
    PH_VAL       = 4'd8,
    PH_VALESC    = 4'd9,
    PH_VALBAD    = 4'd10,
    PH_VALBADESC = 4'd11,
    PH_NEST      = 4'd12,
    PH_NULL      = 4'd13,
    PH_SEP       = 4'd14,
    PH_DONE      = 4'd15
  } phase_t;

  typedef enum logic [1:0] {
    ROLE_SKIP = 2'd0,
    ROLE_KEY  = 2'd1,
    ROLE_STR  = 2'd2,
    ROLE_NEST = 2'd3
  } role_t;

  localparam logic [1:0] KIND_STRING = 2'd0;
  localparam logic [1:0] KIND_NESTED = 2'd1;
  localparam logic [1:0] KIND_NULL   = 2'd2;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_NO_BRACE  = 3'd1;
  localparam logic [2:0] ERR_KEY_START = 3'd2;
  localparam logic [2:0] ERR_UNTERM    = 3'd3;
  localparam logic [2:0] ERR_ESCAPE    = 3'd4;
  localparam logic [2:0] ERR_VALUE     = 3'd5;
  localparam logic [2:0] ERR_NULL      = 3'd6;
  localparam logic [2:0] ERR_DEEP      = 3'd7;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_L      = 8'h6C;

  typedef struct packed {
    phase_t            phase;
    logic [NEST_W-1:0] nest;
  } state_t;

  typedef struct packed {
    logic [2:0] err;
    logic       fin;
    logic [1:0] kind;
    logic       done;
    logic [7:0] ob;
    role_t      role;
  } res_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == 8'd32) || ((b >= 8'd9) && (b <= 8'd13));
  endfunction

  // bit 8 set: escape allowed, low byte is the decoded value
  function automatic logic [8:0] unescape(input logic [7:0] b);
    logic [8:0] r;
    unique case (b)
      CH_N:      r = {1'b1, 8'd10};
      CH_T:      r = {1'b1, 8'd9};
      CH_R:      r = {1'b1, 8'd13};
      CH_QUOTE:  r = {1'b1, CH_QUOTE};
      CH_BSLASH: r = {1'b1, CH_BSLASH};
      default:   r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] null_char(input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0:    c = CH_N;
      2'd1:    c = CH_U;
      default: c = CH_L;
    endcase
    return c;
  endfunction

  function automatic logic [OUT_TDATA_W-1:0] pack_res(input res_t r);
    return OUT_TDATA_W'(r);
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/jsp_step.sv
// ----------------------------------------------------------------------------
// jsp_step
// Per-byte transition: classifies one byte and computes the next parser state and its result.
// ----------------------------------------------------------------------------
`default_nettype none

module jsp_step (
  input  wire jsp_pkg::state_t state,
  input  wire logic [7:0]      data_byte,
  input  wire logic            end_of_text,
  output jsp_pkg::state_t      state_next,
  output jsp_pkg::res_t        res
);

  jsp_pkg::phase_t          ph;
  logic [jsp_pkg::NEST_W-1:0] nl;
  logic [jsp_pkg::NEST_W-1:0] nl_dec;
  logic                     eot;
  logic                     ws;
  logic [8:0]               unesc;
  jsp_pkg::role_t           str_role;
  jsp_pkg::res_t            r;
  jsp_pkg::state_t          s;

  assign ph    = state.phase;
  assign nl    = state.nest;
  assign eot   = end_of_text;
  assign ws    = jsp_pkg::is_ws(data_byte);
  assign unesc = jsp_pkg::unescape(data_byte);
  assign nl_dec = (nl != '0) ? (nl - 1'b1) : nl;
  assign str_role = (ph >= jsp_pkg::PH_VAL) ? jsp_pkg::ROLE_STR : jsp_pkg::ROLE_KEY;

  always_comb begin
    r      = '0;
    r.role = jsp_pkg::ROLE_SKIP;
    s      = state;
    unique case (ph)
      jsp_pkg::PH_BRACE: begin
        if (!eot && data_byte == jsp_pkg::CH_LBRACE) s.phase = jsp_pkg::PH_TOP;
        else r.err = jsp_pkg::ERR_NO_BRACE;
      end
      jsp_pkg::PH_TOP, jsp_pkg::PH_SEP: begin
        if (eot || data_byte == jsp_pkg::CH_RBRACE) begin
          r.fin   = 1'b1;
          s.phase = eot ? jsp_pkg::PH_BRACE : jsp_pkg::PH_DONE;
          s.nest  = '0;
        end else if (data_byte == jsp_pkg::CH_QUOTE) begin
          s.phase = jsp_pkg::PH_KEY;
        end else if (ph == jsp_pkg::PH_SEP && (ws || data_byte == jsp_pkg::CH_COMMA)) begin
          s.phase = ph;
        end else if (ph == jsp_pkg::PH_TOP && ws) begin
          s.phase = jsp_pkg::PH_KEYWS;
        end else begin
          r.err = jsp_pkg::ERR_KEY_START;
        end
      end
      jsp_pkg::PH_KEYWS: begin
        if (!eot && data_byte == jsp_pkg::CH_QUOTE) s.phase = jsp_pkg::PH_KEY;
        else if (eot || !ws) r.err = jsp_pkg::ERR_KEY_START;
      end
      jsp_pkg::PH_KEY, jsp_pkg::PH_VAL: begin
        if (eot) begin
          r.err = jsp_pkg::ERR_UNTERM;
        end else if (data_byte == jsp_pkg::CH_BSLASH) begin
          s.phase = (ph == jsp_pkg::PH_KEY) ? jsp_pkg::PH_KEYESC : jsp_pkg::PH_VALESC;
        end else if (data_byte == jsp_pkg::CH_QUOTE) begin
          if (ph == jsp_pkg::PH_KEY) begin
            s.phase = jsp_pkg::PH_COLON;
          end else begin
            r.done  = 1'b1;
            r.kind  = jsp_pkg::KIND_STRING;
            s.phase = jsp_pkg::PH_SEP;
          end
        end else begin
          r.role = str_role;
          r.ob   = data_byte;
        end
      end
      jsp_pkg::PH_KEYESC, jsp_pkg::PH_VALESC: begin
        if (eot) begin
          r.err = jsp_pkg::ERR_UNTERM;
        end else if (!unesc[8]) begin
          s.phase = (ph == jsp_pkg::PH_KEYESC) ? jsp_pkg::PH_KEYBAD : jsp_pkg::PH_VALBAD;
        end else begin
          r.role  = str_role;
          r.ob    = unesc[7:0];
          s.phase = (ph == jsp_pkg::PH_KEYESC) ? jsp_pkg::PH_KEY : jsp_pkg::PH_VAL;
        end
      end
      jsp_pkg::PH_KEYBAD, jsp_pkg::PH_VALBAD: begin
        if (eot) r.err = jsp_pkg::ERR_UNTERM;
        else if (data_byte == jsp_pkg::CH_QUOTE) r.err = jsp_pkg::ERR_ESCAPE;
        else if (data_byte == jsp_pkg::CH_BSLASH)
          s.phase = (ph == jsp_pkg::PH_KEYBAD) ? jsp_pkg::PH_KEYBADESC : jsp_pkg::PH_VALBADESC;
      end
      jsp_pkg::PH_KEYBADESC, jsp_pkg::PH_VALBADESC: begin
        if (eot) r.err = jsp_pkg::ERR_UNTERM;
        else s.phase = (ph == jsp_pkg::PH_KEYBADESC) ? jsp_pkg::PH_KEYBAD : jsp_pkg::PH_VALBAD;
      end
      jsp_pkg::PH_COLON: begin
        if (eot) begin
          r.err = jsp_pkg::ERR_VALUE;
        end else if (ws || data_byte == jsp_pkg::CH_COLON) begin
          s.phase = ph;
        end else if (data_byte == jsp_pkg::CH_QUOTE) begin
          s.phase = jsp_pkg::PH_VAL;
        end else if (data_byte == jsp_pkg::CH_LBRACE || data_byte == jsp_pkg::CH_LBRACK) begin
          r.role  = jsp_pkg::ROLE_NEST;
          r.ob    = data_byte;
          s.nest  = jsp_pkg::NEST_W'(1);
          s.phase = jsp_pkg::PH_NEST;
        end else if (data_byte == jsp_pkg::CH_N) begin
          s.nest  = jsp_pkg::NEST_W'(1);
          s.phase = jsp_pkg::PH_NULL;
        end else begin
          r.err = jsp_pkg::ERR_VALUE;
        end
      end
      jsp_pkg::PH_NEST: begin
        if (eot) begin
          r.done  = 1'b1;
          r.kind  = jsp_pkg::KIND_NESTED;
          r.fin   = 1'b1;
          s.phase = jsp_pkg::PH_BRACE;
          s.nest  = '0;
        end else if (data_byte == jsp_pkg::CH_LBRACE || data_byte == jsp_pkg::CH_LBRACK) begin
          if (nl >= jsp_pkg::MAX_NEST_V) begin
            r.err = jsp_pkg::ERR_DEEP;
          end else begin
            s.nest = nl + 1'b1;
            r.role = jsp_pkg::ROLE_NEST;
            r.ob   = data_byte;
          end
        end else begin
          r.role = jsp_pkg::ROLE_NEST;
          r.ob   = data_byte;
          if (data_byte == jsp_pkg::CH_RBRACE || data_byte == jsp_pkg::CH_RBRACK) begin
            s.nest = nl_dec;
            if (nl_dec == '0) begin
              r.done  = 1'b1;
              r.kind  = jsp_pkg::KIND_NESTED;
              s.phase = jsp_pkg::PH_SEP;
            end
          end
        end
      end
      jsp_pkg::PH_NULL: begin
        if (!eot && data_byte == jsp_pkg::null_char(nl[1:0])) begin
          if (nl == jsp_pkg::NEST_W'(3)) begin
            r.done  = 1'b1;
            r.kind  = jsp_pkg::KIND_NULL;
            s.nest  = '0;
            s.phase = jsp_pkg::PH_SEP;
          end else begin
            s.nest = nl + 1'b1;
          end
        end else begin
          r.err = jsp_pkg::ERR_NULL;
        end
      end
      jsp_pkg::PH_DONE: begin
        if (eot) begin
          s.phase = jsp_pkg::PH_BRACE;
          s.nest  = '0;
        end
      end
      default: s = state;
    endcase

    if (r.err != jsp_pkg::ERR_NONE) begin
      r.role  = jsp_pkg::ROLE_SKIP;
      r.ob    = '0;
      r.done  = 1'b0;
      r.kind  = '0;
      r.fin   = 1'b0;
      s.phase = eot ? jsp_pkg::PH_BRACE : jsp_pkg::PH_DONE;
      s.nest  = '0;
    end
  end

  assign state_next = s;
  assign res        = r;

endmodule

`default_nettype wire

// File: rtl/core/jsp_skid.sv
// ----------------------------------------------------------------------------
// jsp_skid
// Result register with a skid stage; takes a new result while one waits.
// ----------------------------------------------------------------------------
`default_nettype none

module jsp_skid (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [jsp_pkg::OUT_TDATA_W-1:0] in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [jsp_pkg::OUT_TDATA_W-1:0]      out_data
);

  logic                            skid_valid;
  logic [jsp_pkg::OUT_TDATA_W-1:0] skid_data;
  logic                            push;

  assign in_ready = !skid_valid;
  assign push     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_data <= skid_valid ? skid_data : in_data;
    end else if (push) begin
      skid_data <= in_data;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/json_object_stream_parser_top.sv
// ----------------------------------------------------------------------------
// json_object_stream_parser_top
// Byte-wide JSON object tokenizer with a stream interface on both sides.
// ----------------------------------------------------------------------------
// Each input transaction's result is registered in the result buffer before m_tvalid shows it.
// Throughput: one byte per cycle while the result buffer has room (s_tready high).
// The two-entry result buffer takes one further byte while a result stalls.
// Reset (synchronous): phase to expect opening brace, nest count to zero,
// result buffer emptied.
`default_nettype none

module json_object_stream_parser_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [jsp_pkg::IN_TDATA_W-1:0]  s_tdata,  // [7:0] data_byte
  input  wire logic                            s_tlast,  // end_of_text
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // [1:0] role, [9:2] out_byte, [10] pair_done, [12:11] value_kind,
  // [13] finished, [16:14] error_code, rest zero
  output logic [jsp_pkg::OUT_TDATA_W-1:0]      m_tdata
);

  jsp_pkg::state_t state;
  jsp_pkg::state_t state_next;
  jsp_pkg::res_t   res;
  logic            accept;

  jsp_step u_step (
    .state       (state),
    .data_byte   (s_tdata[7:0]),
    .end_of_text (s_tlast),
    .state_next  (state_next),
    .res         (res)
  );

  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase <= jsp_pkg::PH_BRACE;
      state.nest  <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  jsp_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (jsp_pkg::pack_res(res)),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

`default_nettype wire

// File: rtl/core/jsp_checker.sv
// ----------------------------------------------------------------------------
// jsp_checker
// Port-level checks of the parser's results, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module jsp_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            s_tready,
  input wire logic                            m_tvalid,
  input wire logic                            m_tready,
  input wire logic [jsp_pkg::OUT_TDATA_W-1:0] m_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[16:14] != jsp_pkg::ERR_NONE |->
      m_tdata[1:0] == jsp_pkg::ROLE_SKIP && !m_tdata[10] && !m_tdata[13])
    else $error("error transaction carries payload");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[12:11] != jsp_pkg::KIND_STRING |->
      m_tdata[10] && m_tdata[12:11] <= jsp_pkg::KIND_NULL)
    else $error("value kind without pair completion");

  a_skip_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == jsp_pkg::ROLE_SKIP |-> m_tdata[9:2] == 8'd0)
    else $error("skipped byte not zero");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("result shown or input blocked straight after reset");

endmodule

bind json_object_stream_parser_top jsp_checker u_jsp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the JSON object stream parser. A short table of
// byte transactions covers the edges of the grammar, then generated objects
// (well formed, with corruptions, truncations, noise and one over-deep nested
// value) are streamed in. Results are checked against table values if given,
// else a cycle-free bench tokenizer model; both streams stall at random.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int TEXT_ITEMS = 950;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } text_item_t;

  // res_t pattern order: err, fin, kind, done, ob, role
  typedef struct packed {
    logic [7:0]    b;
    logic          last;
    logic          typed;
    jsp_pkg::res_t want;
  } step_t;

  localparam jsp_pkg::res_t QUIET = '0;
  localparam int N_DIRECTED = 26;
  localparam step_t DIRECTED [N_DIRECTED] = '{
    '{8'h00, 1'b0, 1'b1, '{jsp_pkg::ERR_NO_BRACE, 1'b0, jsp_pkg::KIND_STRING, 1'b0,
                           8'h00, jsp_pkg::ROLE_SKIP}},
    '{8'hFF, 1'b0, 1'b1, QUIET},
    '{8'hA5, 1'b1, 1'b1, QUIET},
    '{jsp_pkg::CH_LBRACE, 1'b0, 1'b0, QUIET},
    '{8'h20, 1'b0, 1'b0, QUIET},
    '{jsp_pkg::CH_RBRACE, 1'b0, 1'b1, '{jsp_pkg::ERR_KEY_START, 1'b0,
                                        jsp_pkg::KIND_STRING, 1'b0, 8'h00,
                                        jsp_pkg::ROLE_SKIP}},
    '{8'h00, 1'b1, 1'b1, QUIET},
    '{jsp_pkg::CH_LBRACE, 1'b0, 1'b0, QUIET},
    '{jsp_pkg::CH_QUOTE, 1'b0, 1'b0, QUIET},
    '{8'hFF, 1'b0, 1'b1, '{jsp_pkg::ERR_NONE, 1'b0, jsp_pkg::KIND_STRING, 1'b0,
                           8'hFF, jsp_pkg::ROLE_KEY}},
    '{jsp_pkg::CH_BSLASH, 1'b0, 1'b0, QUIET},
    '{jsp_pkg::CH_T, 1'b0, 1'b1, '{jsp_pkg::ERR_NONE, 1'b0, jsp_pkg::KIND_STRING, 1'b0,
                                   8'h09, jsp_pkg::ROLE_KEY}},
    '{jsp_pkg::CH_QUOTE, 1'b0, 1'b0, QUIET},
    '{jsp_pkg::CH_COLON, 1'b0, 1'b0, QUIET},
    '{jsp_pkg::CH_N, 1'b0, 1'b0, QUIET},
    '{jsp_pkg::CH_U, 1'b0, 1'b0, QUIET},
    '{jsp_pkg::CH_L, 1'b0, 1'b0, QUIET},
    '{jsp_pkg::CH_L, 1'b0, 1'b1, '{jsp_pkg::ERR_NONE, 1'b0, jsp_pkg::KIND_NULL, 1'b1,
                                   8'h00, jsp_pkg::ROLE_SKIP}},
    '{jsp_pkg::CH_COMMA, 1'b0, 1'b0, QUIET},
    '{jsp_pkg::CH_QUOTE, 1'b0, 1'b0, QUIET},
    '{jsp_pkg::CH_QUOTE, 1'b0, 1'b0, QUIET},
    '{jsp_pkg::CH_LBRACK, 1'b0, 1'b0, QUIET},
    '{8'h00, 1'b1, 1'b1, '{jsp_pkg::ERR_NONE, 1'b1, jsp_pkg::KIND_NESTED, 1'b1,
                           8'h00, jsp_pkg::ROLE_SKIP}},
    '{jsp_pkg::CH_LBRACE, 1'b0, 1'b0, QUIET},
    '{jsp_pkg::CH_RBRACE, 1'b0, 1'b1, '{jsp_pkg::ERR_NONE, 1'b1, jsp_pkg::KIND_STRING,
                                        1'b0, 8'h00, jsp_pkg::ROLE_SKIP}},
    '{8'h5A, 1'b1, 1'b1, QUIET}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [jsp_pkg::IN_TDATA_W-1:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [jsp_pkg::OUT_TDATA_W-1:0] m_tdata;

  json_object_stream_parser_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  jsp_pkg::phase_t            ph = jsp_pkg::PH_BRACE;
  logic [jsp_pkg::NEST_W-1:0] lvl = '0;
  jsp_pkg::res_t              token_q[$];
  text_item_t                 text_q[$];
  bit                         steady = 1'b0;
  int                         fails = 0;
  int                         counted = 0;
  int                         bytes_sent = 0;
  int                         checked = 0;
  int                         pairs_seen = 0;
  int                         objects_ok = 0;
  int                         aborts = 0;
  int                         objs = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic is_blank(input logic [7:0] b);
    return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic logic [8:0] decode_escape(input logic [7:0] b);
    logic [8:0] v;
    case (b)
      jsp_pkg::CH_N:      v = {1'b1, 8'h0A};
      jsp_pkg::CH_T:      v = {1'b1, 8'h09};
      jsp_pkg::CH_R:      v = {1'b1, 8'h0D};
      jsp_pkg::CH_QUOTE:  v = {1'b1, jsp_pkg::CH_QUOTE};
      jsp_pkg::CH_BSLASH: v = {1'b1, jsp_pkg::CH_BSLASH};
      default:            v = 9'd0;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] null_letter(input logic [jsp_pkg::NEST_W-1:0] n);
    logic [7:0] c;
    case (n[1:0])
      2'd0:    c = jsp_pkg::CH_N;
      2'd1:    c = jsp_pkg::CH_U;
      default: c = jsp_pkg::CH_L;
    endcase
    return c;
  endfunction

  function automatic jsp_pkg::res_t tokenize(input logic [7:0] b, input logic eot);
    jsp_pkg::res_t   r;
    jsp_pkg::phase_t cur;
    jsp_pkg::role_t  text_role;
    logic [8:0]      esc;
    logic [2:0]      e;
    r = QUIET;
    cur = ph;
    text_role = (cur >= jsp_pkg::PH_VAL) ? jsp_pkg::ROLE_STR : jsp_pkg::ROLE_KEY;
    case (cur)
      jsp_pkg::PH_BRACE: begin
        if (!eot && b == jsp_pkg::CH_LBRACE) ph = jsp_pkg::PH_TOP;
        else r.err = jsp_pkg::ERR_NO_BRACE;
      end
      jsp_pkg::PH_TOP, jsp_pkg::PH_SEP: begin
        if (eot || b == jsp_pkg::CH_RBRACE) begin
          r.fin = 1'b1;
          ph = eot ? jsp_pkg::PH_BRACE : jsp_pkg::PH_DONE;
          lvl = '0;
        end else if (b == jsp_pkg::CH_QUOTE) ph = jsp_pkg::PH_KEY;
        else if (cur == jsp_pkg::PH_SEP && (is_blank(b) || b == jsp_pkg::CH_COMMA))
          ph = jsp_pkg::PH_SEP;
        else if (cur == jsp_pkg::PH_TOP && is_blank(b)) ph = jsp_pkg::PH_KEYWS;
        else r.err = jsp_pkg::ERR_KEY_START;
      end
      jsp_pkg::PH_KEYWS: begin
        if (!eot && b == jsp_pkg::CH_QUOTE) ph = jsp_pkg::PH_KEY;
        else if (eot || !is_blank(b)) r.err = jsp_pkg::ERR_KEY_START;
      end
      jsp_pkg::PH_KEY, jsp_pkg::PH_VAL: begin
        if (eot) r.err = jsp_pkg::ERR_UNTERM;
        else if (b == jsp_pkg::CH_BSLASH) ph = jsp_pkg::phase_t'(cur + 4'd1);
        else if (b == jsp_pkg::CH_QUOTE) begin
          if (cur == jsp_pkg::PH_KEY) ph = jsp_pkg::PH_COLON;
          else begin
            r.done = 1'b1;
            r.kind = jsp_pkg::KIND_STRING;
            ph = jsp_pkg::PH_SEP;
          end
        end else begin
          r.role = text_role;
          r.ob = b;
        end
      end
      jsp_pkg::PH_KEYESC, jsp_pkg::PH_VALESC: begin
        esc = decode_escape(b);
        if (eot) r.err = jsp_pkg::ERR_UNTERM;
        else if (!esc[8]) ph = jsp_pkg::phase_t'(cur + 4'd1);
        else begin
          r.role = text_role;
          r.ob = esc[7:0];
          ph = jsp_pkg::phase_t'(cur - 4'd1);
        end
      end
      jsp_pkg::PH_KEYBAD, jsp_pkg::PH_VALBAD: begin
        if (eot) r.err = jsp_pkg::ERR_UNTERM;
        else if (b == jsp_pkg::CH_QUOTE) r.err = jsp_pkg::ERR_ESCAPE;
        else if (b == jsp_pkg::CH_BSLASH) ph = jsp_pkg::phase_t'(cur + 4'd1);
      end
      jsp_pkg::PH_KEYBADESC, jsp_pkg::PH_VALBADESC: begin
        if (eot) r.err = jsp_pkg::ERR_UNTERM;
        else ph = jsp_pkg::phase_t'(cur - 4'd1);
      end
      jsp_pkg::PH_COLON: begin
        if (eot) r.err = jsp_pkg::ERR_VALUE;
        else if (is_blank(b) || b == jsp_pkg::CH_COLON) ph = jsp_pkg::PH_COLON;
        else if (b == jsp_pkg::CH_QUOTE) ph = jsp_pkg::PH_VAL;
        else if (b == jsp_pkg::CH_LBRACE || b == jsp_pkg::CH_LBRACK) begin
          r.role = jsp_pkg::ROLE_NEST;
          r.ob = b;
          lvl = jsp_pkg::NEST_W'(1);
          ph = jsp_pkg::PH_NEST;
        end else if (b == jsp_pkg::CH_N) begin
          lvl = jsp_pkg::NEST_W'(1);
          ph = jsp_pkg::PH_NULL;
        end else r.err = jsp_pkg::ERR_VALUE;
      end
      jsp_pkg::PH_NEST: begin
        if (eot) begin
          r.done = 1'b1;
          r.kind = jsp_pkg::KIND_NESTED;
          r.fin = 1'b1;
          ph = jsp_pkg::PH_BRACE;
          lvl = '0;
        end else if (b == jsp_pkg::CH_LBRACE || b == jsp_pkg::CH_LBRACK) begin
          if (lvl >= jsp_pkg::MAX_NEST_V) r.err = jsp_pkg::ERR_DEEP;
          else begin
            lvl = lvl + 1'b1;
            r.role = jsp_pkg::ROLE_NEST;
            r.ob = b;
          end
        end else begin
          r.role = jsp_pkg::ROLE_NEST;
          r.ob = b;
          if (b == jsp_pkg::CH_RBRACE || b == jsp_pkg::CH_RBRACK) begin
            if (lvl != 0) lvl = lvl - 1'b1;
            if (lvl == 0) begin
              r.done = 1'b1;
              r.kind = jsp_pkg::KIND_NESTED;
              ph = jsp_pkg::PH_SEP;
            end
          end
        end
      end
      jsp_pkg::PH_NULL: begin
        if (!eot && b == null_letter(lvl)) begin
          lvl = lvl + 1'b1;
          if (lvl >= 4) begin
            r.done = 1'b1;
            r.kind = jsp_pkg::KIND_NULL;
            lvl = '0;
            ph = jsp_pkg::PH_SEP;
          end
        end else r.err = jsp_pkg::ERR_NULL;
      end
      default: begin
        if (eot) begin
          ph = jsp_pkg::PH_BRACE;
          lvl = '0;
        end
      end
    endcase
    if (r.err != jsp_pkg::ERR_NONE) begin
      e = r.err;
      r = QUIET;
      r.err = e;
      ph = eot ? jsp_pkg::PH_BRACE : jsp_pkg::PH_DONE;
      lvl = '0;
    end
    return r;
  endfunction

  function automatic void put(input logic [7:0] b);
    text_q.push_back(text_item_t'{b, 1'b0});
  endfunction

  function automatic logic [7:0] blank_byte();
    return ($urandom_range(0, 1) == 0) ? 8'h20 : 8'($urandom_range(9, 13));
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (c == jsp_pkg::CH_QUOTE || c == jsp_pkg::CH_BSLASH) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic void put_string();
    logic [7:0] esc_list [5];
    esc_list = '{jsp_pkg::CH_N, jsp_pkg::CH_T, jsp_pkg::CH_R, jsp_pkg::CH_QUOTE,
                 jsp_pkg::CH_BSLASH};
    repeat ($urandom_range(0, 6)) begin
      if ($urandom_range(0, 5) == 0) begin
        put(jsp_pkg::CH_BSLASH);
        if ($urandom_range(0, 4) == 0) put(8'($urandom_range(0, 255)));
        else put(esc_list[$urandom_range(0, 4)]);
      end else put(plain_byte());
    end
    put(jsp_pkg::CH_QUOTE);
  endfunction

  function automatic void put_nested();
    int         depth;
    int         n;
    logic [7:0] c;
    depth = 1;
    n = 0;
    put(($urandom_range(0, 1) == 0) ? jsp_pkg::CH_LBRACE : jsp_pkg::CH_LBRACK);
    while (depth > 0) begin
      n++;
      c = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 9))
        0, 1: if (depth < 5 && n < 24)
          c = ($urandom_range(0, 1) == 0) ? jsp_pkg::CH_LBRACE : jsp_pkg::CH_LBRACK;
        2, 3, 4: c = ($urandom_range(0, 1) == 0) ? jsp_pkg::CH_RBRACE : jsp_pkg::CH_RBRACK;
        default: ;
      endcase
      if (n >= 24) c = jsp_pkg::CH_RBRACK;
      if (c == jsp_pkg::CH_LBRACE || c == jsp_pkg::CH_LBRACK) depth++;
      if (c == jsp_pkg::CH_RBRACE || c == jsp_pkg::CH_RBRACK) depth--;
      put(c);
    end
  endfunction

  function automatic logic [7:0] bad_start_byte();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (c == jsp_pkg::CH_QUOTE || c == jsp_pkg::CH_LBRACE || c == jsp_pkg::CH_LBRACK ||
           c == jsp_pkg::CH_N || c == jsp_pkg::CH_COLON || is_blank(c))
      c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic void put_object(input bit deep);
    int pairs;
    pairs = deep ? 1 : $urandom_range(0, 4);
    put(jsp_pkg::CH_LBRACE);
    if (pairs > 0 && $urandom_range(0, 3) == 0) put(blank_byte());
    for (int i = 0; i < pairs; i++) begin
      if (i > 0) begin
        put(jsp_pkg::CH_COMMA);
        repeat ($urandom_range(0, 2))
          put(($urandom_range(0, 1) == 0) ? jsp_pkg::CH_COMMA : blank_byte());
      end
      put(jsp_pkg::CH_QUOTE);
      put_string();
      repeat ($urandom_range(0, 3))
        put(($urandom_range(0, 2) == 0) ? blank_byte() : jsp_pkg::CH_COLON);
      if (deep) begin
        repeat (jsp_pkg::MAX_NEST + 1) put(jsp_pkg::CH_LBRACK);
      end else begin
        case ($urandom_range(0, 19))
          0: put(bad_start_byte());
          1: begin
            put(jsp_pkg::CH_N);
            put(jsp_pkg::CH_U);
            put(plain_byte());
          end
          2, 3, 4, 5, 6: put_nested();
          7, 8, 9, 10: begin
            put(jsp_pkg::CH_N);
            put(jsp_pkg::CH_U);
            put(jsp_pkg::CH_L);
            put(jsp_pkg::CH_L);
          end
          default: begin
            put(jsp_pkg::CH_QUOTE);
            put_string();
          end
        endcase
      end
    end
    if (pairs > 0)
      repeat ($urandom_range(0, 2))
        put(($urandom_range(0, 1) == 0) ? jsp_pkg::CH_COMMA : blank_byte());
    if ($urandom_range(0, 4) != 0) put(jsp_pkg::CH_RBRACE);
    text_q.push_back(text_item_t'{8'($urandom_range(0, 255)), 1'b1});
  endfunction

  task automatic feed(input logic [7:0] b, input logic last, input logic typed,
                      input jsp_pkg::res_t want);
    jsp_pkg::res_t pred;
    while (!steady && $urandom_range(0, 99) < 27) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pred = tokenize(b, last);
    token_q.push_back(typed ? want : pred);
    bytes_sent++;
    counted++;
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    m_tready <= steady || ($urandom_range(0, 99) >= 27);
  end

  always @(posedge clk) begin : check_results
    jsp_pkg::res_t got;
    jsp_pkg::res_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = jsp_pkg::res_t'(m_tdata[jsp_pkg::RES_W-1:0]);
      if (token_q.size() == 0) begin
        $error("unexpected result transaction, tdata %h", m_tdata);
        fails++;
      end else begin
        want = token_q.pop_front();
        checked++;
        if (got.role != want.role) begin
          $error("role: expected %0d, got %0d", want.role, got.role);
          fails++;
        end
        if (got.ob != want.ob) begin
          $error("out_byte: expected %h, got %h", want.ob, got.ob);
          fails++;
        end
        if (got.done != want.done) begin
          $error("pair_done: expected %0d, got %0d", want.done, got.done);
          fails++;
        end
        if (got.kind != want.kind) begin
          $error("value_kind: expected %0d, got %0d", want.kind, got.kind);
          fails++;
        end
        if (got.fin != want.fin) begin
          $error("finished: expected %0d, got %0d", want.fin, got.fin);
          fails++;
        end
        if (got.err != want.err) begin
          $error("error_code: expected %0d, got %0d", want.err, got.err);
          fails++;
        end
        if (want.done) pairs_seen++;
        if (want.fin) objects_ok++;
        if (want.err != jsp_pkg::ERR_NONE) aborts++;
      end
    end
  end

  initial begin : stimulus
    int cut;
    int start;
    int wait_cycles;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++)
      feed(DIRECTED[i].b, DIRECTED[i].last, DIRECTED[i].typed, DIRECTED[i].want);

    counted = 0;
    while (counted < TEXT_ITEMS) begin
      steady = (counted >= 300 && counted < 450);
      text_q.delete();
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 3))
          text_q.push_back(text_item_t'{8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))});
      start = text_q.size();
      put_object(objs == 4);
      if (objs != 4 && $urandom_range(0, 3) == 0) begin
        cut = $urandom_range(start + 1, text_q.size() - 1);
        if ($urandom_range(0, 1) == 0) text_q[cut].b = 8'($urandom_range(0, 255));
        else begin
          while (text_q.size() > cut) void'(text_q.pop_back());
          text_q.push_back(text_item_t'{8'($urandom_range(0, 255)), 1'b1});
        end
      end
      foreach (text_q[i]) feed(text_q[i].b, text_q[i].last, 1'b0, QUIET);
      objs++;
    end
    steady = 1'b0;
    s_tvalid <= 1'b0;

    wait_cycles = 0;
    while (token_q.size() > 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (8) @(posedge clk);
    if (token_q.size() != 0) begin
      $error("%0d result transactions never arrived", token_q.size());
      fails++;
    end

    $display("Streamed %0d bytes over %0d generated objects; %0d results checked.",
             bytes_sent, objs, checked);
    $display("Seen: %0d completed pairs, %0d accepted objects, %0d error aborts.",
             pairs_seen, objects_ok, aborts);
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
